@@ src/ngfe_pkg.sv @@
// ----------------------------------------------------------------------------
// ngfe_pkg
// shared widths, character codes, result types and helpers of the extractor
// ----------------------------------------------------------------------------
package ngfe_pkg;

  localparam int FIELD_LEN    = 32;
  localparam int SENTENCE_LEN = 128;

  localparam int BYTE_W = 8;
  localparam int SPOS_W = 7;
  localparam int FPOS_W = 5;
  localparam int KIND_W = 3;
  localparam int FNUM_W = 4;
  localparam int HDR_LEN = 6;
  localparam int HCNT_W  = 3;
  localparam int HDR_W   = HDR_LEN * BYTE_W;

  localparam int SCNT_W = $clog2(SENTENCE_LEN + 1);
  localparam int FCNT_W = $clog2(FIELD_LEN + 1);

  localparam int SPOS_MAX = (1 << SPOS_W) - 1;
  localparam int FPOS_MAX = (1 << FPOS_W) - 1;
  localparam int FNUM_MAX = (1 << FNUM_W) - 1;

  localparam logic [HDR_W-1:0] HDR_DEFAULT = 48'h244750474741;  // $GPGGA

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;

  // field numbers of the routed fields
  localparam logic [FNUM_W-1:0] FLD_TIME  = 4'd1;
  localparam logic [FNUM_W-1:0] FLD_LAT   = 4'd2;
  localparam logic [FNUM_W-1:0] FLD_LAT_H = 4'd3;
  localparam logic [FNUM_W-1:0] FLD_LON   = 4'd4;
  localparam logic [FNUM_W-1:0] FLD_LON_H = 4'd5;
  localparam logic [FNUM_W-1:0] FLD_ALT   = 4'd9;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 3'd0,
    KIND_TIME = 3'd1,
    KIND_LAT  = 3'd2,
    KIND_LON  = 3'd3,
    KIND_ALT  = 3'd4
  } field_kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_echo;
    logic              sentence_write;
    logic [SPOS_W-1:0] sentence_pos;
    field_kind_e       field_kind;
    logic [FPOS_W-1:0] field_pos;
    logic              field_overflow;
    logic              frame_end;
    logic              frame_publish;
  } ngfe_result_t;

  // sentence tracker state seen by the header matcher
  typedef struct packed {
    logic in_sentence;
    logic publish_pending;
  } ngfe_status_t;

  function automatic field_kind_e kind_of(input logic [FNUM_W-1:0] fnum);
    field_kind_e k;
    unique case (fnum)
      FLD_TIME:           k = KIND_TIME;
      FLD_LAT, FLD_LAT_H: k = KIND_LAT;
      FLD_LON, FLD_LON_H: k = KIND_LON;
      FLD_ALT:            k = KIND_ALT;
      default:            k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [SPOS_W-1:0] sat_spos(input logic [SCNT_W-1:0] c);
    logic [SPOS_W-1:0] r;
    if (c > SCNT_W'(SPOS_MAX)) begin
      r = SPOS_W'(SPOS_MAX);
    end else begin
      r = SPOS_W'(c);
    end
    return r;
  endfunction

  function automatic logic [FPOS_W-1:0] sat_fpos(input logic [FCNT_W-1:0] c);
    logic [FPOS_W-1:0] r;
    if (c > FCNT_W'(FPOS_MAX)) begin
      r = FPOS_W'(FPOS_MAX);
    end else begin
      r = FPOS_W'(c);
    end
    return r;
  endfunction

endpackage

@@ src/ngfe_in_if.sv @@
// ----------------------------------------------------------------------------
// ngfe_in_if
// received byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface ngfe_in_if import ngfe_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ src/ngfe_out_if.sv @@
// ----------------------------------------------------------------------------
// ngfe_out_if
// classified byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface ngfe_out_if import ngfe_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_echo;
  logic              sentence_write;
  logic [SPOS_W-1:0] sentence_pos;
  logic [KIND_W-1:0] field_kind;
  logic [FPOS_W-1:0] field_pos;
  logic              field_overflow;
  logic              frame_end;
  logic              frame_publish;

  modport source (output valid, output byte_echo, output sentence_write,
                  output sentence_pos, output field_kind, output field_pos,
                  output field_overflow, output frame_end, output frame_publish,
                  input ready);
  modport sink   (input valid, input byte_echo, input sentence_write,
                  input sentence_pos, input field_kind, input field_pos,
                  input field_overflow, input frame_end, input frame_publish,
                  output ready);
endinterface

@@ src/ngfe_hdr.sv @@
// ----------------------------------------------------------------------------
// ngfe_hdr
// header hunt: collects a dollar and the five bytes after it and compares with the tag
// ----------------------------------------------------------------------------
module ngfe_hdr import ngfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [HDR_W-1:0]  pattern_i,
  input  ngfe_status_t      status_i,
  output logic              match_o
);

  localparam int HB_N = HDR_LEN - 1;

  logic [BYTE_W-1:0] hb_q [HB_N];
  logic [BYTE_W-1:0] hb_d [HB_N];
  logic [HCNT_W-1:0] hc_q, hc_d;
  logic              hunt;

  assign hunt = !status_i.in_sentence && !status_i.publish_pending;

  always_comb begin
    hb_d    = hb_q;
    hc_d    = hc_q;
    match_o = 1'b0;
    if (hunt) begin
      priority if (byte_i == CH_DOLLAR) begin
        hb_d[0] = byte_i;
        hc_d    = HCNT_W'(1);
      end else if (hc_q == HCNT_W'(HB_N)) begin
        // sixth byte: compare against the tag straight from the input
        match_o = ({hb_q[0], hb_q[1], hb_q[2], hb_q[3], hb_q[4], byte_i} == pattern_i);
        hc_d    = '0;
      end else if (hc_q != '0) begin
        hb_d[hc_q] = byte_i;
        hc_d       = hc_q + HCNT_W'(1);
      end else begin
        hc_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= '0;
      for (int i = 0; i < HB_N; i++) begin
        hb_q[i] <= '0;
      end
    end else if (step_i) begin
      hc_q <= hc_d;
      hb_q <= hb_d;
    end
  end

endmodule

@@ src/ngfe_body.sv @@
// ----------------------------------------------------------------------------
// ngfe_body
// sentence tracker: buffer position, comma count and field routing
// ----------------------------------------------------------------------------
module ngfe_body import ngfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              match_i,
  output ngfe_status_t      status_o,
  output ngfe_result_t      res_o
);

  logic              in_s_q, in_s_d;
  logic              pend_q, pend_d;
  logic [FNUM_W-1:0] fn_q, fn_d;
  logic [SCNT_W-1:0] sc_q, sc_d;
  logic [FCNT_W-1:0] fc_q [4];
  logic [FCNT_W-1:0] fc_d [4];

  logic              in_s;
  logic [SCNT_W-1:0] sc;
  field_kind_e       kind;
  logic [1:0]        idx;

  assign status_o.in_sentence     = in_s_q;
  assign status_o.publish_pending = pend_q;

  always_comb begin
    res_o           = '0;
    res_o.byte_echo = byte_i;
    in_s_d = in_s_q;
    pend_d = pend_q;
    fn_d   = fn_q;
    sc_d   = sc_q;
    fc_d   = fc_q;
    in_s   = in_s_q | match_i;
    // on a match the position skips header bytes one to five, which this block does not write
    sc     = match_i ? SCNT_W'(HDR_LEN - 1) : sc_q;
    kind   = kind_of(fn_q);
    idx    = 2'(KIND_W'(kind) - KIND_W'(1));
    if (pend_q) begin
      pend_d              = 1'b0;
      res_o.frame_publish = 1'b1;
    end else if (in_s) begin
      if (byte_i != CH_CR) begin
        in_s_d = 1'b1;
        sc_d   = sc;
        if (sc < SCNT_W'(SENTENCE_LEN)) begin
          res_o.sentence_write = 1'b1;
          res_o.sentence_pos   = sat_spos(sc);
          sc_d                 = sc + SCNT_W'(1);
        end else begin
          res_o.field_overflow = 1'b1;
        end
        if (byte_i == CH_COMMA) begin
          if (fn_q != FNUM_W'(FNUM_MAX)) begin
            fn_d = fn_q + FNUM_W'(1);
          end
        end else if (kind != KIND_NONE) begin
          res_o.field_kind = kind;
          res_o.field_pos  = sat_fpos(fc_q[idx]);
          if (fc_q[idx] < FCNT_W'(FIELD_LEN)) begin
            fc_d[idx] = fc_q[idx] + FCNT_W'(1);
          end else begin
            res_o.field_overflow = 1'b1;
          end
        end
      end else begin
        // carriage return closes the frame, next byte is swallowed
        res_o.frame_end    = 1'b1;
        res_o.sentence_pos = sat_spos(sc);
        in_s_d = 1'b0;
        pend_d = 1'b1;
        fn_d   = '0;
        sc_d   = '0;
        for (int i = 0; i < 4; i++) begin
          fc_d[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_s_q <= 1'b0;
      pend_q <= 1'b0;
      fn_q   <= '0;
      sc_q   <= '0;
      for (int i = 0; i < 4; i++) begin
        fc_q[i] <= '0;
      end
    end else if (step_i) begin
      in_s_q <= in_s_d;
      pend_q <= pend_d;
      fn_q   <= fn_d;
      sc_q   <= sc_d;
      fc_q   <= fc_d;
    end
  end

endmodule

@@ src/nmea_gga_field_extractor.sv @@
// ----------------------------------------------------------------------------
// nmea_gga_field_extractor
// classifies received bytes of a tagged sentence into buffer and field slots
// ----------------------------------------------------------------------------
// a byte is held in the input register and its result in the result register
// throughput: one byte per cycle while res_o.ready does not stall the result register; the state update
//   lies between the input register and the result register
// reset: asynchronous, active low; clears all counters and flags and loads
//   the header tag with $GPGGA
module nmea_gga_field_extractor import ngfe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [HDR_W-1:0] cfg_data_i,
  ngfe_in_if.sink          rx_i,
  ngfe_out_if.source       res_o
);

  // header tag register
  logic [HDR_W-1:0] pattern_q;

  // input register
  logic              in_v_q;
  logic [BYTE_W-1:0] in_b_q;

  // result register
  logic              out_v_q;
  ngfe_result_t      res_q;

  logic              advance;
  logic              match;
  ngfe_status_t      status;
  ngfe_result_t      res;

  // the input stage moves on whenever the result register is free or drained
  assign advance    = in_v_q && (!out_v_q || res_o.ready);
  assign rx_i.ready = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= HDR_DEFAULT;
    end else if (cfg_we_i) begin
      pattern_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      in_v_q <= 1'b1;
    end else if (advance) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_b_q <= rx_i.rx_byte;
    end
  end

  // header hunt, runs only outside a sentence and not while a publish is pending
  ngfe_hdr u_hdr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_b_q),
    .pattern_i (pattern_q),
    .status_i  (status),
    .match_o   (match)
  );

  // sentence tracking and field routing
  ngfe_body u_body (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_b_q),
    .match_i  (match),
    .status_o (status),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign res_o.valid          = out_v_q;
  assign res_o.byte_echo      = res_q.byte_echo;
  assign res_o.sentence_write = res_q.sentence_write;
  assign res_o.sentence_pos   = res_q.sentence_pos;
  assign res_o.field_kind     = res_q.field_kind;
  assign res_o.field_pos      = res_q.field_pos;
  assign res_o.field_overflow = res_q.field_overflow;
  assign res_o.frame_end      = res_q.frame_end;
  assign res_o.frame_publish  = res_q.frame_publish;

endmodule
